[hw/rtl/npc_pkg.sv]
`timescale 1ns / 1ps

package npc_pkg;

    localparam int PALETTE_DEPTH = 64;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int COUNT_W       = 7;
    localparam int CHAN_W        = 8;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int COLOR_W       = 3 * CHAN_W;
    localparam int NUMBER_W      = 16;
    localparam int DIST_W        = 18;
    localparam int WORD_W        = COLOR_W + NUMBER_W;

    localparam int RED_SHIFT     = 16;
    localparam int GREEN_SHIFT   = 8;

    typedef enum logic {
        ACTION_LOAD     = 1'b0,
        ACTION_CLASSIFY = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Tag that travels alongside one palette entry through the read and distance stages
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

    // Last slot searched: zero counts as one, large counts saturate at the depth
    function automatic logic [IDX_W-1:0] last_index(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] m;
        if (n == '0) begin
            m = '0;
        end else if (n > COUNT_W'(PALETTE_DEPTH)) begin
            m = COUNT_W'(PALETTE_DEPTH - 1);
        end else begin
            m = n - COUNT_W'(1);
        end
        return m[IDX_W-1:0];
    endfunction

    // Square of the absolute difference of two channel values
    function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

[hw/rtl/npc_palette_ram.sv]
`timescale 1ns / 1ps

module npc_palette_ram (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [npc_pkg::IDX_W-1:0]        waddr,
    input  logic [npc_pkg::WORD_W-1:0]       wdata,
    input  logic                             re,
    input  logic [npc_pkg::IDX_W-1:0]        raddr,
    output logic [npc_pkg::WORD_W-1:0]       rdata
);

    logic [npc_pkg::WORD_W-1:0] mem [npc_pkg::PALETTE_DEPTH];
    logic [npc_pkg::WORD_W-1:0] rdata_reg;

    // Write one palette slot
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/npc_dist_unit.sv]
`timescale 1ns / 1ps

module npc_dist_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [npc_pkg::WORD_W-1:0]        entry_word,
    input  npc_pkg::tag_t                     entry_tag,
    input  logic [npc_pkg::COLOR_W-1:0]       pixel,
    output npc_pkg::tag_t                     res_tag,
    output logic [npc_pkg::NUMBER_W-1:0]      res_number,
    output logic [npc_pkg::DIST_W-1:0]        res_dist
);

    logic [npc_pkg::COLOR_W-1:0]  color;
    logic [npc_pkg::SQ_W-1:0]     sq_r_next, sq_g_next, sq_b_next;
    logic [npc_pkg::SQ_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [npc_pkg::NUMBER_W-1:0] number_reg;
    npc_pkg::tag_t                tag_reg;

    assign color = entry_word[npc_pkg::COLOR_W-1:0];

    // Per-channel squared differences
    assign sq_r_next = npc_pkg::chan_sq(color[npc_pkg::RED_SHIFT +: npc_pkg::CHAN_W],
                                        pixel[npc_pkg::RED_SHIFT +: npc_pkg::CHAN_W]);
    assign sq_g_next = npc_pkg::chan_sq(color[npc_pkg::GREEN_SHIFT +: npc_pkg::CHAN_W],
                                        pixel[npc_pkg::GREEN_SHIFT +: npc_pkg::CHAN_W]);
    assign sq_b_next = npc_pkg::chan_sq(color[npc_pkg::CHAN_W-1:0],
                                        pixel[npc_pkg::CHAN_W-1:0]);

    // Hold the squares with the entry tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= entry_tag;
        end
    end

    always_ff @(posedge aclk) begin
        sq_r_reg   <= sq_r_next;
        sq_g_reg   <= sq_g_next;
        sq_b_reg   <= sq_b_next;
        number_reg <= entry_word[npc_pkg::WORD_W-1:npc_pkg::COLOR_W];
    end

    // Sum of the three channel terms
    assign res_dist   = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                      + npc_pkg::DIST_W'(sq_b_reg);
    assign res_tag    = tag_reg;
    assign res_number = number_reg;

endmodule

[hw/rtl/npc_ctrl.sv]
`timescale 1ns / 1ps

module npc_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  npc_pkg::action_t                  s_action,
    input  logic [npc_pkg::COLOR_W-1:0]       s_pixel,
    output logic                              s_ready,
    input  logic [npc_pkg::COUNT_W-1:0]       num_entries,
    output logic                              rd_en,
    output logic [npc_pkg::IDX_W-1:0]         rd_addr,
    output npc_pkg::tag_t                     rd_tag,
    output logic [npc_pkg::COLOR_W-1:0]       pixel,
    input  npc_pkg::tag_t                     res_tag,
    input  logic [npc_pkg::NUMBER_W-1:0]      res_number,
    input  logic [npc_pkg::DIST_W-1:0]        res_dist,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [npc_pkg::NUMBER_W-1:0]      m_color_number,
    output logic [npc_pkg::DIST_W-1:0]        m_distance_squared,
    output logic [npc_pkg::IDX_W-1:0]         m_entry_found
);

    npc_pkg::state_t               state_reg, state_next;
    logic [npc_pkg::IDX_W-1:0]     addr_reg, addr_next;
    logic [npc_pkg::IDX_W-1:0]     last_idx_reg;
    logic [npc_pkg::COLOR_W-1:0]   pixel_reg;
    npc_pkg::tag_t                 rd_tag_reg, rd_tag_next;
    logic [npc_pkg::DIST_W-1:0]    best_dist_reg;
    logic [npc_pkg::IDX_W-1:0]     best_idx_reg;
    logic [npc_pkg::NUMBER_W-1:0]  best_number_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [npc_pkg::NUMBER_W-1:0]  m_number_reg;
    logic [npc_pkg::DIST_W-1:0]    m_dist_reg;
    logic [npc_pkg::IDX_W-1:0]     m_idx_reg;
    logic                          start;
    logic                          issue_last;
    logic                          take;
    logic                          out_load;

    assign start      = s_valid && s_ready && (s_action == npc_pkg::ACTION_CLASSIFY);
    assign issue_last = (addr_reg == last_idx_reg);
    // Strictly smaller keeps the lowest slot on a tie
    assign take       = res_tag.valid && ((res_tag.idx == '0) || (res_dist < best_dist_reg));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npc_pkg::ST_IDLE: begin
                if (start) state_next = npc_pkg::ST_SCAN;
            end
            npc_pkg::ST_SCAN: begin
                if (issue_last) state_next = npc_pkg::ST_DRAIN;
            end
            npc_pkg::ST_DRAIN: begin
                if (res_tag.valid && res_tag.last) state_next = npc_pkg::ST_DONE;
            end
            npc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = npc_pkg::ST_IDLE;
            end
            default: state_next = npc_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            npc_pkg::ST_IDLE:  s_ready  = 1'b1;
            npc_pkg::ST_SCAN:  rd_en    = 1'b1;
            npc_pkg::ST_DRAIN: rd_en    = 1'b0;
            npc_pkg::ST_DONE:  out_load = !m_valid_reg || m_ready;
            default:           s_ready  = 1'b0;
        endcase
    end

    // Read address and the tag that follows the read data
    always_comb begin
        addr_next = addr_reg;
        if (start) begin
            addr_next = '0;
        end else if (rd_en && !issue_last) begin
            addr_next = addr_reg + npc_pkg::IDX_W'(1);
        end
        rd_tag_next.valid = rd_en;
        rd_tag_next.last  = issue_last;
        rd_tag_next.idx   = addr_reg;
    end

    // Output register: load from the best entry, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= npc_pkg::ST_IDLE;
            addr_reg    <= '0;
            rd_tag_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_tag_reg  <= rd_tag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the request and track the running best
    always_ff @(posedge aclk) begin
        if (start) begin
            pixel_reg    <= s_pixel;
            last_idx_reg <= npc_pkg::last_index(num_entries);
        end
        if (take) begin
            best_dist_reg   <= res_dist;
            best_idx_reg    <= res_tag.idx;
            best_number_reg <= res_number;
        end
        if (out_load) begin
            m_number_reg <= best_number_reg;
            m_dist_reg   <= best_dist_reg;
            m_idx_reg    <= best_idx_reg;
        end
    end

    assign rd_addr            = addr_reg;
    assign rd_tag             = rd_tag_reg;
    assign pixel              = pixel_reg;
    assign m_valid            = m_valid_reg;
    assign m_color_number     = m_number_reg;
    assign m_distance_squared = m_dist_reg;
    assign m_entry_found      = m_idx_reg;

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == npc_pkg::ST_IDLE) |-> !res_tag.valid)
        else $error("distance result arrived with no search running");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == npc_pkg::ST_SCAN) |-> (addr_reg <= last_idx_reg))
        else $error("read address passed the last searched slot");

    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == npc_pkg::ST_DONE) |-> (best_idx_reg <= last_idx_reg))
        else $error("best slot outside the searched range");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == npc_pkg::ST_DONE))
        else $error("result presented without a finished search");

endmodule

[hw/rtl/nearest_palette_color.sv]
`timescale 1ns / 1ps

// Nearest palette color search.
// Input stream s_*: tuser selects the request kind (0 loads a palette slot,
// 1 classifies a pixel); tdata carries slot index, slot color, slot number and
// pixel. A load request gives no result. A classify request walks slots
// 0 .. num_entries-1 one per cycle through a registered palette memory read
// and a shared distance unit, so s_tready stays low until the search is done
// and its result is loaded into the output register.
// Result stream m_*: color number, squared distance and slot index of the
// nearest slot, lowest slot winning ties. The result sits in an output register;
// while the receiver stalls, the search that finishes next waits for it.
// cfg_*: writes num_entries (reset value 1; 0 acts as 1, above 64 saturates).
// Reset (aresetn low, synchronous) returns to idle and drops any pending
// result; palette contents are kept and must be loaded before they are searched.
module nearest_palette_color (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata, low bit up: entry_index[5:0], entry_color[23:0], entry_number[15:0],
    // pixel[23:0], two zero pad bits
    input  logic [71:0] s_tdata,
    // tuser: action
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata, low bit up: color_number[15:0], distance_squared[17:0], entry_found[5:0]
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [6:0]  cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);

    logic [npc_pkg::COUNT_W-1:0]  num_entries_reg;
    logic [npc_pkg::IDX_W-1:0]    entry_index;
    logic [npc_pkg::COLOR_W-1:0]  entry_color;
    logic [npc_pkg::NUMBER_W-1:0] entry_number;
    logic [npc_pkg::COLOR_W-1:0]  s_pixel;
    npc_pkg::action_t             action;
    logic                         ram_we;
    logic                         rd_en;
    logic [npc_pkg::IDX_W-1:0]    rd_addr;
    logic [npc_pkg::WORD_W-1:0]   rd_word;
    npc_pkg::tag_t                rd_tag;
    npc_pkg::tag_t                res_tag;
    logic [npc_pkg::NUMBER_W-1:0] res_number;
    logic [npc_pkg::DIST_W-1:0]   res_dist;
    logic [npc_pkg::COLOR_W-1:0]  pixel;
    logic [npc_pkg::NUMBER_W-1:0] m_color_number;
    logic [npc_pkg::DIST_W-1:0]   m_distance_squared;
    logic [npc_pkg::IDX_W-1:0]    m_entry_found;

    // Unpack the request
    assign entry_index  = s_tdata[5:0];
    assign entry_color  = s_tdata[29:6];
    assign entry_number = s_tdata[45:30];
    assign s_pixel      = s_tdata[69:46];
    assign action       = npc_pkg::action_t'(s_tuser);

    // Slot count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_entries_reg <= npc_pkg::COUNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            num_entries_reg <= cfg_data;
        end
    end

    // Palette load
    assign ram_we = s_tvalid && s_tready && (action == npc_pkg::ACTION_LOAD);

    npc_palette_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (entry_index),
        .wdata ({entry_number, entry_color}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    npc_dist_unit u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .entry_word (rd_word),
        .entry_tag  (rd_tag),
        .pixel      (pixel),
        .res_tag    (res_tag),
        .res_number (res_number),
        .res_dist   (res_dist)
    );

    npc_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_tvalid),
        .s_action           (action),
        .s_pixel            (s_pixel),
        .s_ready            (s_tready),
        .num_entries        (num_entries_reg),
        .rd_en              (rd_en),
        .rd_addr            (rd_addr),
        .rd_tag             (rd_tag),
        .pixel              (pixel),
        .res_tag            (res_tag),
        .res_number         (res_number),
        .res_dist           (res_dist),
        .m_valid            (m_tvalid),
        .m_ready            (m_tready),
        .m_color_number     (m_color_number),
        .m_distance_squared (m_distance_squared),
        .m_entry_found      (m_entry_found)
    );

    // Pack the result
    assign m_tdata = {m_entry_found, m_distance_squared, m_color_number};

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = npc_pkg::PALETTE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int PHASE_ITEMS   = 135;
    localparam int NUM_PHASES    = 8;

    typedef struct {
        npc_pkg::action_t                 action;
        logic [npc_pkg::IDX_W-1:0]        entry_index;
        logic [npc_pkg::COLOR_W-1:0]      entry_color;
        logic [npc_pkg::NUMBER_W-1:0]     entry_number;
        logic [npc_pkg::COLOR_W-1:0]      pixel;
    } palette_req_t;

    typedef struct {
        logic [npc_pkg::NUMBER_W-1:0]     color_number;
        logic [npc_pkg::DIST_W-1:0]       distance_squared;
        logic [npc_pkg::IDX_W-1:0]        entry_found;
    } match_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [71:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [6:0]  cfg_data  = 7'd1;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    // Palette copy and entry count that the expected matches are computed from
    logic [npc_pkg::COLOR_W-1:0]  palette_color_model  [npc_pkg::PALETTE_DEPTH];
    logic [npc_pkg::NUMBER_W-1:0] palette_number_model [npc_pkg::PALETTE_DEPTH];
    logic [npc_pkg::COUNT_W-1:0]  search_limit = 7'd1;

    // Stimulus-side view: colors loaded so far and the slots a search covers
    logic [npc_pkg::COLOR_W-1:0]  gen_color [npc_pkg::PALETTE_DEPTH];
    int                           gen_span = 1;

    palette_req_t pending_requests[$];
    palette_req_t req_on_bus;
    match_t       expected_matches[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int phase_counts [NUM_PHASES] = '{64, 5, 127, 1, 17, 0, 2, 40};

    nearest_palette_color u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Squared RGB distance over the three 8-bit channels
    function automatic logic [npc_pkg::DIST_W-1:0] rgb_distance(
        input logic [npc_pkg::COLOR_W-1:0] a,
        input logic [npc_pkg::COLOR_W-1:0] b);
        int dr, dg, db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return npc_pkg::DIST_W'(dr * dr + dg * dg + db * db);
    endfunction

    // Scan the active slots; a strictly smaller distance is needed to move off a slot
    function automatic match_t nearest_entry(input logic [npc_pkg::COLOR_W-1:0] pix);
        match_t                     m;
        int                         span;
        logic [npc_pkg::DIST_W-1:0] d;
        if (search_limit == 0) begin
            span = 1;
        end else if (search_limit > npc_pkg::PALETTE_DEPTH) begin
            span = npc_pkg::PALETTE_DEPTH;
        end else begin
            span = int'(search_limit);
        end
        m.entry_found      = '0;
        m.distance_squared = rgb_distance(palette_color_model[0], pix);
        for (int i = 1; i < span; i++) begin
            d = rgb_distance(palette_color_model[i], pix);
            if (d < m.distance_squared) begin
                m.distance_squared = d;
                m.entry_found      = npc_pkg::IDX_W'(i);
            end
        end
        m.color_number = palette_number_model[m.entry_found];
        return m;
    endfunction

    function automatic logic [npc_pkg::COLOR_W-1:0] saturated_color();
        return {($urandom_range(1) == 1) ? 8'hFF : 8'h00,
                ($urandom_range(1) == 1) ? 8'hFF : 8'h00,
                ($urandom_range(1) == 1) ? 8'hFF : 8'h00};
    endfunction

    task automatic queue_load(input logic [npc_pkg::IDX_W-1:0] slot,
                              input logic [npc_pkg::COLOR_W-1:0] color,
                              input logic [npc_pkg::NUMBER_W-1:0] number);
        palette_req_t r;
        r.action       = npc_pkg::ACTION_LOAD;
        r.entry_index  = slot;
        r.entry_color  = color;
        r.entry_number = number;
        r.pixel        = npc_pkg::COLOR_W'($urandom);
        pending_requests.push_back(r);
        gen_color[slot] = color;
    endtask

    task automatic queue_classify(input logic [npc_pkg::COLOR_W-1:0] pix);
        palette_req_t r;
        r.action       = npc_pkg::ACTION_CLASSIFY;
        r.entry_index  = npc_pkg::IDX_W'($urandom);
        r.entry_color  = npc_pkg::COLOR_W'($urandom);
        r.entry_number = npc_pkg::NUMBER_W'($urandom);
        r.pixel        = pix;
        pending_requests.push_back(r);
    endtask

    // Mostly classify requests, about half of them aimed at or near loaded colors, with loads mixed in
    task automatic queue_random_requests(input int n);
        logic [npc_pkg::COLOR_W-1:0] c;
        logic [npc_pkg::IDX_W-1:0]   slot;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 40) begin
                if ($urandom_range(1) == 1) begin
                    slot = npc_pkg::IDX_W'($urandom_range(gen_span - 1, 0));
                end else begin
                    slot = npc_pkg::IDX_W'($urandom);
                end
                case ($urandom_range(3))
                    0:       c = gen_color[$urandom_range(gen_span - 1, 0)];
                    1:       c = saturated_color();
                    default: c = npc_pkg::COLOR_W'($urandom);
                endcase
                queue_load(slot, c, npc_pkg::NUMBER_W'($urandom));
            end else begin
                c = gen_color[$urandom_range(gen_span - 1, 0)];
                case ($urandom_range(5))
                    0, 1: c = npc_pkg::COLOR_W'($urandom);
                    2:    c = c ^ {6'b0, 2'($urandom), 6'b0, 2'($urandom), 6'b0, 2'($urandom)};
                    3:    c = c ^ {4'b0, 4'($urandom), 4'b0, 4'($urandom), 4'b0, 4'($urandom)};
                    4:    c = saturated_color();
                    default: ;
                endcase
                queue_classify(c);
            end
        end
    endtask

    // Hold until every request went out and every match came back, then let the block settle
    task automatic wait_until_idle();
        @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_matches.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_entry_count(input logic [npc_pkg::COUNT_W-1:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        search_limit = value;
        if (value == 0) begin
            gen_span = 1;
        end else if (value > npc_pkg::PALETTE_DEPTH) begin
            gen_span = npc_pkg::PALETTE_DEPTH;
        end else begin
            gen_span = int'(value);
        end
        @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Request driver: present the next pending request, model it once accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (req_on_bus.action == npc_pkg::ACTION_LOAD) begin
                    palette_color_model[req_on_bus.entry_index]  = req_on_bus.entry_color;
                    palette_number_model[req_on_bus.entry_index] = req_on_bus.entry_number;
                end else begin
                    expected_matches.push_back(nearest_entry(req_on_bus.pixel));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_on_bus = pending_requests.pop_front();
                    s_tdata  <= {2'b00, req_on_bus.pixel, req_on_bus.entry_number,
                                 req_on_bus.entry_color, req_on_bus.entry_index};
                    s_tuser  <= req_on_bus.action;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each match with the oldest expectation
    always @(posedge aclk) begin : result_monitor
        match_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_matches.size() == 0) begin
                    note_mismatch("unexpected result, tdata", 0, m_tdata);
                end else begin
                    want = expected_matches.pop_front();
                    if (m_tdata[15:0] !== want.color_number)
                        note_mismatch("color_number", want.color_number, m_tdata[15:0]);
                    if (m_tdata[33:16] !== want.distance_squared)
                        note_mismatch("distance_squared", want.distance_squared, m_tdata[33:16]);
                    if (m_tdata[39:34] !== want.entry_found)
                        note_mismatch("entry_found", want.entry_found, m_tdata[39:34]);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int mode;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: channel extremes against slot 0, reset entry count of one
        queue_load(6'd0, 24'h000000, 16'h0000);
        queue_classify(24'hFFFFFF);
        queue_classify(24'h000000);
        queue_load(6'd0, 24'hFFFFFF, 16'hFFFF);
        queue_classify(24'h000000);
        queue_load(6'd63, 24'h808080, 16'hA5A5);
        queue_classify(24'h7F7F7F);
        wait_until_idle();

        // Zero entry count still searches slot 0
        write_entry_count(7'd0);
        queue_classify(24'h123456);
        queue_load(6'd1, 24'h102030, 16'h0001);
        queue_load(6'd2, 24'h102030, 16'h0002);
        queue_load(6'd3, 24'h00FF00, 16'h0003);
        wait_until_idle();

        // Equal colors in slots 1 and 2: lower slot must win the tie
        write_entry_count(7'd4);
        queue_classify(24'h102030);
        queue_classify(24'h00FF00);
        queue_classify(24'h000000);
        queue_classify(24'hF0F0F0);
        wait_until_idle();

        // Load every slot so any entry count is safe to search
        for (int i = 0; i < npc_pkg::PALETTE_DEPTH; i++) begin
            queue_load(npc_pkg::IDX_W'(i), npc_pkg::COLOR_W'($urandom),
                       npc_pkg::NUMBER_W'($urandom));
        end
        wait_until_idle();

        // Random phases, cycling through the idle/stall mixes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_entry_count(npc_pkg::COUNT_W'(phase_counts[p]));
            mode           = p % 4;
            send_idle_pct  = (mode == 1) ? 55 : (mode == 3) ? 37 : 0;
            recv_stall_pct = (mode == 2) ? 55 : (mode == 3) ? 37 : 0;
            queue_random_requests(PHASE_ITEMS);
            wait_until_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_matches.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
